[rtl/core/i2cbe_pkg.sv]
// Package for the I2C master byte engine: opcodes, pin and payload structs.
// Used by the sequencer, the output buffer and the top level.
package i2cbe_pkg;

  localparam logic [2:0] OP_START    = 3'd0;
  localparam logic [2:0] OP_STOP     = 3'd1;
  localparam logic [2:0] OP_WRITE    = 3'd2;
  localparam logic [2:0] OP_READ     = 3'd3;
  localparam logic [2:0] OP_READ_ACK = 3'd4;
  localparam logic [2:0] OP_SEND_ACK = 3'd5;

  localparam logic [7:0] HALF_PERIOD_RESET = 8'd2;
  localparam logic [3:0] BITS_PER_BYTE     = 4'd8;
  localparam logic [3:0] BITS_PER_ACK      = 4'd1;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } pins_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic       ack_bit;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;
  } res_t;

endpackage

[rtl/core/i2cbe_if.sv]
// Channel interfaces of the I2C master byte engine: tick input, status output
// and configuration write. Depends on nothing but plain logic types.
interface i2cbe_tick_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] opcode;
  logic [7:0] data_byte;
  logic       ack_bit;
  logic       sda_in;

  modport source (output valid, cmd_valid, opcode, data_byte, ack_bit, sda_in, input ready);
  modport sink (input valid, cmd_valid, opcode, data_byte, ack_bit, sda_in, output ready);
endinterface

interface i2cbe_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_seen;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  read_data, ack_seen, input ready);
  modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                read_data, ack_seen, output ready);
endinterface

interface i2cbe_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] half_period_ticks;

  modport source (output valid, half_period_ticks, input ready);
  modport sink (input valid, half_period_ticks, output ready);
endinterface

[rtl/core/i2cbe_seq.sv]
// Bus sequencer of the I2C master byte engine: phase, counters, shift and pin
// registers, and the status beat that each tick produces. Uses i2cbe_pkg.
module i2cbe_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         half_period_ticks,
  input  logic               push,
  input  i2cbe_pkg::tick_t   tick,
  output i2cbe_pkg::res_t    res_next
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_A,
    PH_START_B,
    PH_STOP_A,
    PH_STOP_B,
    PH_BIT_LOW,
    PH_BIT_HIGH
  } phase_t;

  phase_t              phase, phase_next;
  logic [2:0]          active_op, active_op_next;
  logic [3:0]          bit_count, bit_count_next;
  logic [7:0]          shift_reg, shift_reg_next;
  logic [7:0]          tick_count, tick_count_next;
  i2cbe_pkg::pins_t    pins, pins_next;
  logic                ack_reg, ack_reg_next;
  logic [7:0]          read_reg, read_reg_next;
  logic                done;

  logic [7:0] seg_len;
  logic [7:0] tick_inc;
  logic [3:0] bit_inc;
  logic [3:0] bit_total;
  logic [7:0] shift_in;

  assign seg_len   = (half_period_ticks == 8'd0) ? 8'd1 : half_period_ticks;
  assign tick_inc  = (tick_count == 8'hFF) ? tick_count : tick_count + 8'd1;
  assign bit_inc   = bit_count + 4'd1;
  assign bit_total = (active_op == i2cbe_pkg::OP_WRITE || active_op == i2cbe_pkg::OP_READ)
                     ? i2cbe_pkg::BITS_PER_BYTE : i2cbe_pkg::BITS_PER_ACK;
  assign shift_in  = {shift_reg[6:0], tick.sda_in};

  always_comb begin
    phase_next      = phase;
    active_op_next  = active_op;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    tick_count_next = tick_count;
    pins_next       = pins;
    ack_reg_next    = ack_reg;
    read_reg_next   = read_reg;
    done            = 1'b0;

    if (phase == PH_IDLE) begin
      if (tick.cmd_valid && tick.opcode <= i2cbe_pkg::OP_SEND_ACK) begin
        active_op_next  = tick.opcode;
        tick_count_next = 8'd0;
        bit_count_next  = 4'd0;
        phase_next      = PH_BIT_LOW;
        case (tick.opcode)
          i2cbe_pkg::OP_START: begin
            pins_next  = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
            phase_next = PH_START_A;
          end
          i2cbe_pkg::OP_STOP: begin
            pins_next  = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
            phase_next = PH_STOP_A;
          end
          i2cbe_pkg::OP_WRITE: begin
            // First data bit goes out with SCL low straight away.
            pins_next      = '{scl: 1'b0, sda: tick.data_byte[7], drv: 1'b1};
            shift_reg_next = {tick.data_byte[6:0], 1'b0};
          end
          i2cbe_pkg::OP_READ: begin
            shift_reg_next = 8'd0;
            pins_next      = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
          end
          i2cbe_pkg::OP_READ_ACK: begin
            pins_next = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
          end
          default: begin
            pins_next = '{scl: 1'b0, sda: tick.ack_bit, drv: 1'b1};
          end
        endcase
      end
    end else begin
      tick_count_next = tick_inc;
      if (tick_inc >= seg_len) begin
        tick_count_next = 8'd0;
        unique case (phase)
          PH_START_A: begin
            pins_next  = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
            phase_next = PH_START_B;
          end
          PH_START_B: begin
            pins_next  = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
          PH_STOP_A: begin
            pins_next  = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
            phase_next = PH_STOP_B;
          end
          PH_STOP_B: begin
            pins_next  = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
          PH_BIT_LOW: begin
            pins_next.scl = 1'b1;
            phase_next    = PH_BIT_HIGH;
          end
          PH_BIT_HIGH: begin
            // Sampling happens at the end of the SCL high segment.
            if (active_op == i2cbe_pkg::OP_READ) begin
              shift_reg_next = shift_in;
            end
            if (active_op == i2cbe_pkg::OP_READ_ACK) begin
              ack_reg_next = tick.sda_in;
            end
            bit_count_next = bit_inc;
            pins_next.scl  = 1'b0;
            if (bit_inc < bit_total) begin
              if (active_op == i2cbe_pkg::OP_WRITE) begin
                pins_next      = '{scl: 1'b0, sda: shift_reg[7], drv: 1'b1};
                shift_reg_next = {shift_reg[6:0], 1'b0};
              end
              phase_next = PH_BIT_LOW;
            end else begin
              if (active_op != i2cbe_pkg::OP_SEND_ACK) begin
                pins_next = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
              end
              if (active_op == i2cbe_pkg::OP_READ) begin
                read_reg_next = shift_in;
              end
              phase_next = PH_IDLE;
              done       = 1'b1;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      active_op  <= 3'd0;
      bit_count  <= 4'd0;
      shift_reg  <= 8'd0;
      tick_count <= 8'd0;
      pins       <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
      ack_reg    <= 1'b1;
      read_reg   <= 8'd0;
    end else if (push) begin
      phase      <= phase_next;
      active_op  <= active_op_next;
      bit_count  <= bit_count_next;
      shift_reg  <= shift_reg_next;
      tick_count <= tick_count_next;
      pins       <= pins_next;
      ack_reg    <= ack_reg_next;
      read_reg   <= read_reg_next;
    end
  end

  always_comb begin
    res_next.scl_level = pins_next.scl;
    res_next.sda_level = pins_next.sda;
    res_next.sda_drive = pins_next.drv;
    res_next.busy_res  = (phase_next != PH_IDLE);
    res_next.done_res  = done;
    res_next.read_data = read_reg_next;
    res_next.ack_seen  = ack_reg_next;
  end

  // A completing command always leaves the engine idle in the same beat.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    push && done |-> phase_next == PH_IDLE)
    else $error("done raised while the sequencer stays busy");

  // The bit counter never runs past one byte.
  a_bit_count: assert property (@(posedge clk) disable iff (rst)
    bit_count <= i2cbe_pkg::BITS_PER_BYTE)
    else $error("bit counter beyond a byte");

  // SCL follows the bit phase: low in the low segment, high in the high one.
  a_scl_phase: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BIT_LOW |-> !pins.scl) and (phase == PH_BIT_HIGH |-> pins.scl))
    else $error("SCL level disagrees with the bit phase");

endmodule

[rtl/core/i2cbe_skid.sv]
// Two-entry output buffer of the I2C master byte engine, so that the input
// ready is a register and not a path from the output ready. Uses i2cbe_pkg.
module i2cbe_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  i2cbe_pkg::res_t  push_data,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output i2cbe_pkg::res_t  out_data
);

  logic            spare_valid;
  i2cbe_pkg::res_t spare_data;
  logic            pop;

  assign pop      = out_valid && out_ready;
  assign can_push = !spare_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (spare_valid) begin
      if (pop) begin
        out_data    <= spare_data;
        spare_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        spare_data  <= push_data;
        spare_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // The spare entry is only ever filled behind a held output beat.
  a_spare_behind: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> out_valid)
    else $error("spare entry holds a beat with the output empty");

endmodule

[rtl/core/i2c_master_byte_engine.sv]
// Top level of the I2C master byte engine: configuration register and the
// wiring of sequencer and output buffer. Uses i2cbe_pkg and i2cbe_if.sv.
//
// This block is a bit-level I2C master sequencer. Every beat on the tick
// channel is one bus tick; it may carry a command (start, stop, write byte
// MSB first, read byte, read the slave ACK, send ACK or NACK) and always
// carries the sampled SDA pin. A command is only taken when the engine is
// idle; others are ignored, as are opcodes six and seven. For every tick beat
// exactly one status beat comes out with the SCL level, the SDA level and
// drive enable, busy, a one-tick done pulse, the last byte read and the last
// slave ACK seen. Each SCL half period lasts half_period_ticks ticks (zero
// behaves as one), written through the configuration channel, which is
// always ready and should be written while the engine is idle. Read bits are
// sampled on the tick that ends an SCL high segment. The engine takes one
// tick per clock cycle while the output buffer has room: the whole sequencer
// step is a single pass of logic from the state registers into the status
// buffer, which registers each status beat. A two-entry output buffer keeps
// tick ready a register; ready drops only once two status beats are waiting.
module i2c_master_byte_engine (
  input logic        clk,
  input logic        rst,
  i2cbe_cfg_if.sink  cfg,
  i2cbe_tick_if.sink tick,
  i2cbe_res_if.source status
);

  logic             half_period_ticks;
  logic [7:0]       half_period;
  logic             accept;
  logic             can_push;
  i2cbe_pkg::tick_t tick_data;
  i2cbe_pkg::res_t  res_next;
  i2cbe_pkg::res_t  res_out;

  // The half period register takes every write at once.
  assign cfg.ready         = 1'b1;
  assign half_period_ticks = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= i2cbe_pkg::HALF_PERIOD_RESET;
    end else if (half_period_ticks) begin
      half_period <= cfg.half_period_ticks;
    end
  end

  // A tick is taken whenever the output buffer has room for its status beat.
  assign tick.ready = can_push;
  assign accept     = tick.valid && tick.ready;

  always_comb begin
    tick_data.cmd_valid = tick.cmd_valid;
    tick_data.opcode    = tick.opcode;
    tick_data.data_byte = tick.data_byte;
    tick_data.ack_bit   = tick.ack_bit;
    tick_data.sda_in    = tick.sda_in;
  end

  i2cbe_seq u_seq (
    .clk               (clk),
    .rst               (rst),
    .half_period_ticks (half_period),
    .push              (accept),
    .tick              (tick_data),
    .res_next          (res_next)
  );

  i2cbe_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res_next),
    .can_push  (can_push),
    .out_valid (status.valid),
    .out_ready (status.ready),
    .out_data  (res_out)
  );

  assign status.scl_level = res_out.scl_level;
  assign status.sda_level = res_out.sda_level;
  assign status.sda_drive = res_out.sda_drive;
  assign status.busy_res  = res_out.busy_res;
  assign status.done_res  = res_out.done_res;
  assign status.read_data = res_out.read_data;
  assign status.ack_seen  = res_out.ack_seen;

endmodule
